/* hdl/stnd_pkg.sv */
package stnd_pkg;

	localparam int ArgW   = 6;
	localparam int ValueW = 63;

	localparam int MaxNFirstDef  = 20;
	localparam int MaxNSecondDef = 25;

	localparam logic OpFirst  = 1'b0;
	localparam logic OpSecond = 1'b1;

	localparam logic StatusOk      = 1'b0;
	localparam logic StatusInvalid = 1'b1;

	typedef struct packed {
		logic load;
		logic row_start;
		logic step_first;
		logic step;
		logic row_end;
		logic fin_read;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic special;
		logic j_one;
		logic last_row;
	} sts_t;

endpackage

/* hdl/stnd_if.sv */
interface stnd_query_if;
	import stnd_pkg::*;

	logic            valid;
	logic            ready;
	logic            op;
	logic [ArgW-1:0] n;
	logic [ArgW-1:0] k;

	modport source (output valid, output op, output n, output k, input ready);
	modport sink (input valid, input op, input n, input k, output ready);
endinterface

interface stnd_result_if;
	import stnd_pkg::*;

	logic              valid;
	logic              ready;
	logic [ValueW-1:0] value;
	logic              status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface

/* hdl/stirling_number_dp_core.sv */
// Stirling number unit: one request (op, n, k) gives one result, the unsigned
// first-kind number c(n,k) for op 0 or the second-kind number S(n,k) for op 1,
// exact in 63 bits, or status 1 with value 0 when k > n or n exceeds the kind
// limit. Requests with k = 0, k = n or invalid arguments skip the row sweep.
// Otherwise the triangle is swept row by row on one multiply-add unit and a
// row memory with one read and one write port, one column a cycle.
// One request is in flight at a time; a new one is taken once the result has
// been moved to the output register, which holds it until it is taken.
module stirling_number_dp_core #(
	parameter int MAX_N_FIRST  = stnd_pkg::MaxNFirstDef,
	parameter int MAX_N_SECOND = stnd_pkg::MaxNSecondDef
) (
	input logic          clk,
	input logic          arst_n,
	stnd_query_if.sink   query,
	stnd_result_if.source result
);
	import stnd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	stnd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query.valid),
		.query_ready  (query.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.cmd          (cmd),
		.sts          (sts)
	);

	stnd_dp #(
		.MAX_N_FIRST  (MAX_N_FIRST),
		.MAX_N_SECOND (MAX_N_SECOND)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.in_op  (query.op),
		.in_n   (query.n),
		.in_k   (query.k),
		.value  (result.value),
		.status (result.status)
	);

endmodule

/* hdl/stnd_dp.sv */
module stnd_dp #(
	parameter int MAX_N_FIRST  = stnd_pkg::MaxNFirstDef,
	parameter int MAX_N_SECOND = stnd_pkg::MaxNSecondDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  stnd_pkg::cmd_t              cmd,
	output stnd_pkg::sts_t              sts,
	input  logic                        in_op,
	input  logic [stnd_pkg::ArgW-1:0]   in_n,
	input  logic [stnd_pkg::ArgW-1:0]   in_k,
	output logic [stnd_pkg::ValueW-1:0] value,
	output logic                        status
);
	import stnd_pkg::*;

	localparam int MaxN  = (MAX_N_FIRST > MAX_N_SECOND) ? MAX_N_FIRST : MAX_N_SECOND;
	localparam int Depth = MaxN + 1;
	localparam int IW    = $clog2(Depth);

	logic              op_q;
	logic [ArgW-1:0]   n_q;
	logic [ArgW-1:0]   k_q;
	logic [IW-1:0]     i_q;
	logic [IW-1:0]     j_q;
	logic [ValueW-1:0] prod_q;
	logic [ValueW-1:0] rdata_q;
	logic [ValueW-1:0] row_mem [Depth];

	logic [ArgW-1:0]      limit;
	logic                 invalid;
	logic                 special;
	logic [ValueW-1:0]    spec_value;
	logic [IW-1:0]        k_s;
	logic                 fresh;
	logic [IW-1:0]        top;
	logic [IW-1:0]        mult_idx;
	logic [ValueW-1:0]    mult_opd;
	logic [ValueW+IW-1:0] product;
	logic [ValueW-1:0]    sum;
	logic                 we;
	logic [IW-1:0]        waddr;
	logic [ValueW-1:0]    wdata;
	logic [IW-1:0]        raddr;

	always_comb begin
		limit   = (op_q == OpFirst) ? ArgW'(MAX_N_FIRST) : ArgW'(MAX_N_SECOND);
		invalid = (k_q > n_q) || (n_q > limit);
		special = invalid || (k_q == '0) || (k_q == n_q);
		if (invalid) begin
			spec_value = '0;
		end else if (k_q == '0) begin
			spec_value = ValueW'(n_q == '0);
		end else begin
			spec_value = ValueW'(1);
		end
	end

	assign k_s   = k_q[IW-1:0];
	assign fresh = (k_s >= i_q);
	assign top   = fresh ? i_q : k_s;

	always_comb begin
		if (op_q == OpFirst) begin
			mult_idx = i_q - IW'(1);
		end else if (cmd.step_first) begin
			mult_idx = j_q;
		end else begin
			mult_idx = j_q - IW'(1);
		end
	end

	// a column beyond the previous row starts from zero
	assign mult_opd = (cmd.step_first && fresh) ? '0 : rdata_q;
	assign product  = {{IW{1'b0}}, mult_opd} * {{ValueW{1'b0}}, mult_idx};
	assign sum      = prod_q + rdata_q;

	always_comb begin
		we    = cmd.load || cmd.step || cmd.row_end;
		waddr = cmd.step ? j_q : '0;
		if (cmd.load) begin
			wdata = ValueW'(1);
		end else if (cmd.step) begin
			wdata = sum;
		end else begin
			wdata = '0;
		end
		raddr = '0;
		if (cmd.row_start) begin
			raddr = top;
		end else if (cmd.step_first) begin
			raddr = j_q - IW'(1);
		end else if (cmd.step && (j_q >= IW'(2))) begin
			raddr = j_q - IW'(2);
		end else if (cmd.fin_read) begin
			raddr = k_s;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			row_mem[waddr] <= wdata;
		end
		rdata_q <= row_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_op;
			n_q  <= in_n;
			k_q  <= in_k;
		end
		if (cmd.step_first || cmd.step) begin
			prod_q <= product[ValueW-1:0];
		end
		if (cmd.out_load) begin
			value  <= special ? spec_value : rdata_q;
			status <= invalid ? StatusInvalid : StatusOk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else begin
			if (cmd.load) begin
				i_q <= IW'(1);
			end else if (cmd.row_end) begin
				i_q <= i_q + IW'(1);
			end
			if (cmd.row_start) begin
				j_q <= top;
			end else if (cmd.step) begin
				j_q <= j_q - IW'(1);
			end
		end
	end

	assign sts.special  = special;
	assign sts.j_one    = (j_q == IW'(1));
	assign sts.last_row = (ArgW'(i_q) == n_q);

endmodule

/* hdl/stnd_ctrl.sv */
module stnd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           query_valid,
	output logic           query_ready,
	output logic           result_valid,
	input  logic           result_ready,
	output stnd_pkg::cmd_t cmd,
	input  stnd_pkg::sts_t sts
);
	import stnd_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CHECK  = 4'd1;
	localparam logic [3:0] S_ROWST  = 4'd2;
	localparam logic [3:0] S_STEP1  = 4'd3;
	localparam logic [3:0] S_STEP   = 4'd4;
	localparam logic [3:0] S_ROWEND = 4'd5;
	localparam logic [3:0] S_FRD    = 4'd6;
	localparam logic [3:0] S_OUT    = 4'd7;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign query_ready  = (state_q == S_IDLE);
	assign accept       = query_valid && query_ready;
	assign out_free     = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.load       = accept;
		cmd.row_start  = (state_q == S_ROWST);
		cmd.step_first = (state_q == S_STEP1);
		cmd.step       = (state_q == S_STEP);
		cmd.row_end    = (state_q == S_ROWEND);
		cmd.fin_read   = (state_q == S_FRD) || (state_q == S_OUT);
		cmd.out_load   = (state_q == S_OUT) && out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = sts.special ? S_OUT : S_ROWST;
			end
			S_ROWST: begin
				state_d = S_STEP1;
			end
			S_STEP1: begin
				state_d = S_STEP;
			end
			S_STEP: begin
				if (sts.j_one) begin
					state_d = S_ROWEND;
				end
			end
			S_ROWEND: begin
				state_d = sts.last_row ? S_FRD : S_ROWST;
			end
			S_FRD: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_CHECK))
		else $error("accepted request did not start the check");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_OUT) && !out_free) |=> ((state_q == S_OUT) && out_valid_q))
		else $error("pending result lost while output stalled");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (result_valid && (state_q == S_IDLE)))
		else $error("result load did not raise valid");

	a_step_run: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_STEP) && !sts.j_one) |=> (state_q == S_STEP))
		else $error("column sweep left early");

endmodule
